// ===== hdl/rgbhsv_pkg.sv =====
// shared widths and constants for the 8-bit rgb to hsv converter
`default_nettype none

package rgbhsv_pkg;

	// pixel channel width
	localparam int PIX_W = 8;

	// quotient bits, one restoring step per pipeline stage
	localparam int QUO_W = 8;

	// dividend width: 361*d and 510*d + mx both stay below 2**17
	localparam int DIV_W = 17;

	// divisor width: 2*d and 2*mx
	localparam int DVS_W = PIX_W + 1;

	// signed hue numerator: up to 5*d, down to -d
	localparam int NUM_W = PIX_W + 4;

	// signed scaled hue before wrap
	localparam int T_W = DIV_W + 2;

	// arithmetic constants
	localparam int HUE_SCALE  = 60;
	localparam int FULL_TURN  = 360;
	localparam int SAT_SCALE  = 510;
	localparam int HUE_MAX    = 180;

	// front stages ahead of the divider
	localparam int FRONT_STAGES = 3;

	// clock edges from the start edge to the edge that takes the result
	localparam int PIPE_LAT = FRONT_STAGES + QUO_W;

endpackage

`default_nettype wire

// ===== hdl/rgb_to_hsv_8bit.sv =====
// Pixel pipeline: a transaction taken at a clock edge passes the front stages and the
// divider stages; done is driven straight from the valid bit of the last divider stage.
// Throughput is one pixel per clock; busy stays low since the receiver cannot stall.
// Depth is set by the two restoring dividers, one quotient bit per stage, eight stages.
// arst_n clears all valid bits at once; no transaction is in flight after reset.
`default_nettype none

module rgb_to_hsv_8bit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [rgbhsv_pkg::PIX_W-1:0] red,
	input  logic [rgbhsv_pkg::PIX_W-1:0] green,
	input  logic [rgbhsv_pkg::PIX_W-1:0] blue,
	output logic                         done,
	output logic [rgbhsv_pkg::PIX_W-1:0] hue,
	output logic [rgbhsv_pkg::PIX_W-1:0] saturation,
	output logic [rgbhsv_pkg::PIX_W-1:0] brightness
);
	import rgbhsv_pkg::*;

	typedef enum logic [1:0] {SEC_RED, SEC_GREEN, SEC_BLUE} sector_t;

	// payload of one divider stage
	typedef struct packed {
		logic             grey;
		logic [PIX_W-1:0] mx;
		logic [DIV_W-1:0] hrem;
		logic [DVS_W-1:0] hdvs;
		logic [QUO_W-1:0] hquo;
		logic [DIV_W-1:0] srem;
		logic [DVS_W-1:0] sdvs;
		logic [QUO_W-1:0] squo;
	} div_st_t;

	// never stalls
	assign busy = 1'b0;

	logic take;
	assign take = start && !busy;

	// stage 1: pick the largest channel, smallest channel and hue difference
	sector_t                 sec_c;
	logic [PIX_W-1:0]        mx_c;
	logic [PIX_W-1:0]        mn_c;
	logic signed [PIX_W:0]   diff_c;

	always_comb begin
		if (red >= green && red >= blue) begin
			sec_c  = SEC_RED;
			mx_c   = red;
			mn_c   = (green < blue) ? green : blue;
			diff_c = $signed({1'b0, green}) - $signed({1'b0, blue});
		end else if (green >= blue) begin
			sec_c  = SEC_GREEN;
			mx_c   = green;
			mn_c   = (red < blue) ? red : blue;
			diff_c = $signed({1'b0, blue}) - $signed({1'b0, red});
		end else begin
			sec_c  = SEC_BLUE;
			mx_c   = blue;
			mn_c   = (red < green) ? red : green;
			diff_c = $signed({1'b0, red}) - $signed({1'b0, green});
		end
	end

	logic                  vld_s1;
	sector_t               sec_s1;
	logic [PIX_W-1:0]      mx_s1;
	logic [PIX_W-1:0]      mn_s1;
	logic signed [PIX_W:0] diff_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		sec_s1  <= sec_c;
		mx_s1   <= mx_c;
		mn_s1   <= mn_c;
		diff_s1 <= diff_c;
	end

	// stage 2: spread and hue numerator with the sector offset
	logic [PIX_W-1:0]        d_c;
	logic signed [NUM_W-1:0] d_ext_c;
	logic signed [NUM_W-1:0] num_c;

	assign d_c     = mx_s1 - mn_s1;
	assign d_ext_c = $signed(NUM_W'(d_c));

	always_comb begin
		case (sec_s1)
			SEC_RED:   num_c = NUM_W'(diff_s1);
			SEC_GREEN: num_c = NUM_W'(diff_s1) + (d_ext_c <<< 1);
			SEC_BLUE:  num_c = NUM_W'(diff_s1) + (d_ext_c <<< 2);
			default:   num_c = NUM_W'(diff_s1);
		endcase
	end

	logic                    vld_s2;
	logic                    grey_s2;
	logic [PIX_W-1:0]        mx_s2;
	logic [PIX_W-1:0]        d_s2;
	logic signed [NUM_W-1:0] num_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		grey_s2 <= (d_c == '0);
		mx_s2   <= mx_s1;
		d_s2    <= d_c;
		num_s2  <= num_c;
	end

	// stage 3: scaled dividends, negative hue wraps by a full turn
	logic signed [T_W-1:0] d_t_c;
	logic signed [T_W-1:0] wrap_c;
	logic signed [T_W-1:0] t_c;
	logic [DIV_W-1:0]      sden_c;

	assign d_t_c  = $signed(T_W'(d_s2));
	assign wrap_c = (num_s2 < 0) ? d_t_c * T_W'(FULL_TURN) : '0;
	assign t_c    = T_W'(num_s2) * T_W'(HUE_SCALE) + wrap_c + d_t_c;
	assign sden_c = DIV_W'(d_s2) * DIV_W'(SAT_SCALE) + DIV_W'(mx_s2);

	logic    vld_s3;
	div_st_t div_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		div_s3.grey <= grey_s2;
		div_s3.mx   <= mx_s2;
		div_s3.hrem <= t_c[DIV_W-1:0];
		div_s3.hdvs <= {d_s2, 1'b0};
		div_s3.hquo <= '0;
		div_s3.srem <= sden_c;
		div_s3.sdvs <= {mx_s2, 1'b0};
		div_s3.squo <= '0;
	end

	// stages 4 to 11: restoring division, most significant quotient bit first
	logic    div_vld_s [QUO_W];
	div_st_t div_s     [QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		localparam int BIT = QUO_W - 1 - k;

		logic             src_vld;
		div_st_t          src;
		div_st_t          nxt;
		logic [DIV_W-1:0] hsh;
		logic [DIV_W-1:0] ssh;
		logic             hge;
		logic             sge;

		if (k == 0) begin : g_first
			assign src_vld = vld_s3;
			assign src     = div_s3;
		end else begin : g_next
			assign src_vld = div_vld_s[k-1];
			assign src     = div_s[k-1];
		end

		// trial subtract of the shifted divisors
		always_comb begin
			hsh            = DIV_W'(src.hdvs) << BIT;
			ssh            = DIV_W'(src.sdvs) << BIT;
			hge            = (src.hrem >= hsh);
			sge            = (src.srem >= ssh);
			nxt            = src;
			nxt.hrem       = hge ? (src.hrem - hsh) : src.hrem;
			nxt.srem       = sge ? (src.srem - ssh) : src.srem;
			nxt.hquo[BIT]  = hge;
			nxt.squo[BIT]  = sge;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[k] <= 1'b0;
			end else begin
				div_vld_s[k] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			div_s[k] <= nxt;
		end
	end

	// result ports, grey pixels force hue and saturation to zero
	assign done       = div_vld_s[QUO_W-1];
	assign hue        = div_s[QUO_W-1].grey ? '0 : div_s[QUO_W-1].hquo;
	assign saturation = div_s[QUO_W-1].grey ? '0 : div_s[QUO_W-1].squo;
	assign brightness = div_s[QUO_W-1].mx;

endmodule

`default_nettype wire

// ===== hdl/rgbhsv_chk.sv =====
// port level checker for the rgb to hsv converter, with its bind
`default_nettype none

module rgbhsv_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic [rgbhsv_pkg::PIX_W-1:0] red,
	input logic [rgbhsv_pkg::PIX_W-1:0] green,
	input logic [rgbhsv_pkg::PIX_W-1:0] blue,
	input logic                         done,
	input logic [rgbhsv_pkg::PIX_W-1:0] hue,
	input logic [rgbhsv_pkg::PIX_W-1:0] saturation,
	input logic [rgbhsv_pkg::PIX_W-1:0] brightness
);
	import rgbhsv_pkg::*;

	// every accepted transaction comes out after the fixed latency
	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(PIPE_LAT) done)
		else $error("accepted transaction did not produce a result in time");

	// no result without a matching accepted transaction
	a_lat_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LAT))
		else $error("result without a matching transaction");

	// brightness is the largest channel of the transaction it belongs to
	a_bright: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (brightness >= $past(red, PIPE_LAT)
			&& brightness >= $past(green, PIPE_LAT)
			&& brightness >= $past(blue, PIPE_LAT)
			&& (brightness == $past(red, PIPE_LAT)
				|| brightness == $past(green, PIPE_LAT)
				|| brightness == $past(blue, PIPE_LAT))))
		else $error("brightness is not the largest channel");

	// hue range, and zero saturation only for grey pixels which carry zero hue
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hue <= PIX_W'(HUE_MAX)))
		else $error("hue above its range");

	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturation == '0) |-> (hue == '0))
		else $error("zero saturation with nonzero hue");

endmodule

bind rgb_to_hsv_8bit rgbhsv_chk u_rgbhsv_chk (.*);

`default_nettype wire

// ===== verif/tb_rgb_to_hsv_8bit.sv =====
// self-checking testbench for the 8-bit rgb to hsv pixel converter
`timescale 1ns / 100ps

module tb_rgb_to_hsv_8bit;
	import rgbhsv_pkg::*;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		pix_t hue;
		pix_t saturation;
		pix_t brightness;
	} hsv_t;

	// cycles with no accepted transaction and no result before the run is declared hung
	localparam int STALL_LIMIT = 1000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	pix_t red = '0;
	pix_t green = '0;
	pix_t blue = '0;
	logic busy;
	logic done;
	pix_t hue;
	pix_t saturation;
	pix_t brightness;

	hsv_t expected_hsv[$];
	int err_count = 0;
	int stall_cycles = 0;
	int gap_pct = 0;

	rgb_to_hsv_8bit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.red(red),
		.green(green),
		.blue(blue),
		.done(done),
		.hue(hue),
		.saturation(saturation),
		.brightness(brightness)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// exact hsv of one pixel, hue in units of two degrees rounded half up
	function automatic hsv_t convert_pixel(pix_t r, pix_t g, pix_t b);
		int ri;
		int gi;
		int bi;
		int mx;
		int mn;
		int spread;
		int num;
		int scaled;
		hsv_t res;
		ri = r;
		gi = g;
		bi = b;
		mx = (ri > gi) ? ri : gi;
		mx = (mx > bi) ? mx : bi;
		mn = (ri < gi) ? ri : gi;
		mn = (mn < bi) ? mn : bi;
		spread = mx - mn;
		res.brightness = pix_t'(mx);
		res.hue = '0;
		res.saturation = '0;
		if (spread > 0) begin
			// sector order: red, then green, then blue
			if (mx == ri)
				num = gi - bi;
			else if (mx == gi)
				num = bi - ri + 2 * spread;
			else
				num = ri - gi + 4 * spread;
			scaled = HUE_SCALE * num;
			if (scaled < 0)
				scaled += FULL_TURN * spread;
			res.hue = pix_t'((scaled + spread) / (2 * spread));
			res.saturation = pix_t'((SAT_SCALE * spread + mx) / (2 * mx));
		end
		return res;
	endfunction

	// predict on accept, check each done strobe against the oldest prediction
	always @(posedge clk) begin
		hsv_t exp_hsv;
		if (arst_n) begin
			if (start && !busy)
				expected_hsv.push_back(convert_pixel(red, green, blue));
			if (done) begin
				if (expected_hsv.size() == 0) begin
					$error("result with no transaction pending: hue %0d sat %0d val %0d",
						hue, saturation, brightness);
					err_count++;
				end else begin
					exp_hsv = expected_hsv.pop_front();
					if (hue !== exp_hsv.hue) begin
						$error("hue mismatch: expected %0d, got %0d", exp_hsv.hue, hue);
						err_count++;
					end
					if (saturation !== exp_hsv.saturation) begin
						$error("saturation mismatch: expected %0d, got %0d",
							exp_hsv.saturation, saturation);
						err_count++;
					end
					if (brightness !== exp_hsv.brightness) begin
						$error("brightness mismatch: expected %0d, got %0d",
							exp_hsv.brightness, brightness);
						err_count++;
					end
				end
			end
		end
	end

	// watchdog on cycles without any accepted transaction or result
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// drive one pixel from a falling edge and hold it until accepted
	task automatic send_pixel(input pix_t r, input pix_t g, input pix_t b);
		// idle with a fresh draw per pass, so gap_pct is the share of idle cycles
		while ($urandom_range(99) < gap_pct) begin
			start = 1'b0;
			red = pix_t'($urandom);
			green = pix_t'($urandom);
			blue = pix_t'($urandom);
			@(negedge clk);
		end
		red = r;
		green = g;
		blue = b;
		start = 1'b1;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	// random pixel, biased toward greys, ties and dark values
	task automatic random_pixel(output pix_t r, output pix_t g, output pix_t b);
		int pick;
		pick = $urandom_range(15);
		r = pix_t'($urandom);
		g = pix_t'($urandom);
		b = pix_t'($urandom);
		case (pick)
			0: begin
				g = r;
				b = r;
			end
			1: g = r;
			2: b = g;
			3: b = r;
			4: begin
				r = pix_t'($urandom_range(3));
				g = pix_t'($urandom_range(3));
				b = pix_t'($urandom_range(3));
			end
			default: ;
		endcase
	endtask

	// stop sending until every pending transaction has come back
	task automatic wait_drained();
		start = 1'b0;
		while (expected_hsv.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// extremes, primaries, ties and the hue wrap
	task automatic test_corner_pixels();
		gap_pct = 0;
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd200, 8'd200, 8'd10);
		send_pixel(8'd10, 8'd200, 8'd200);
		send_pixel(8'd200, 8'd10, 8'd200);
		// red largest with blue above green wraps near 180
		send_pixel(8'd255, 8'd0, 8'd1);
		send_pixel(8'd255, 8'd254, 8'd255);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd1);
		send_pixel(8'd255, 8'd254, 8'd254);
		send_pixel(8'd254, 8'd255, 8'd255);
		send_pixel(8'd1, 8'd2, 8'd3);
		send_pixel(8'd170, 8'd85, 8'd0);
		send_pixel(8'd85, 8'd170, 8'd255);
		send_pixel(8'd100, 8'd50, 8'd75);
		wait_drained();
	endtask

	// random stream at a given sender idle rate
	task automatic test_random_stream(input int count, input int idle_pct);
		pix_t r;
		pix_t g;
		pix_t b;
		gap_pct = idle_pct;
		for (int i = 0; i < count; i++) begin
			random_pixel(r, g, b);
			send_pixel(r, g, b);
		end
	endtask

	// short bursts, each followed by a full drain
	task automatic test_drain_pause();
		pix_t r;
		pix_t g;
		pix_t b;
		gap_pct = 0;
		for (int k = 0; k < 5; k++) begin
			for (int i = 0; i < 8; i++) begin
				random_pixel(r, g, b);
				send_pixel(r, g, b);
			end
			wait_drained();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_corner_pixels();
		test_random_stream(200, 0);
		test_random_stream(200, 59);
		test_drain_pause();
		test_random_stream(200, 13);
		test_random_stream(150, 0);

		// let the pipeline empty out
		start = 1'b0;
		while (expected_hsv.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 4) @(posedge clk);
		if (err_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
